// ----- rtl/spm_pkg.sv -----
// Shared types, constants and helpers for the square-wave span meter.
// Used by spm_div and adc_square_wave_span_meter_core; no dependencies.
package spm_pkg;

  // Field and datapath widths
  localparam int VOLT_W    = 24;
  localparam int CNT_W     = 16;
  localparam int RATIO_W   = 10;
  localparam int MV_W      = 15;
  localparam int PROD_W    = MV_W + RATIO_W;
  localparam int SUM_W     = VOLT_W + CNT_W;
  localparam int DIV_DEN_W = (CNT_W > RATIO_W) ? CNT_W : RATIO_W;
  localparam int CFG_IDX_W = 2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_NUM = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OVP = 2'd2;

  // Status byte decoding
  localparam logic [7:0] STATUS_CFG_MASK   = 8'h70;
  localparam logic [7:0] STATUS_CFG_EXPECT = 8'h10;
  localparam int         STATUS_BUSY_BIT   = 7;

  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_ERROR = 2'd1,
    OP_CLOSE = 2'd2,
    OP_NONE  = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    KIND_READY    = 3'd0,
    KIND_BUSY     = 3'd1,
    KIND_MISMATCH = 3'd2,
    KIND_ERROR    = 3'd3,
    KIND_SUMMARY  = 3'd4
  } kind_t;

  typedef struct packed {
    logic [1:0]         opcode;
    logic signed [15:0] sample_word;
    logic [7:0]         status_byte;
  } in_t;

  typedef struct packed {
    logic [2:0]        result_kind;
    logic [VOLT_W-1:0] scaled_mv;
    logic              over_voltage;
    logic              drive_level;
    logic [VOLT_W-1:0] span_mv;
    logic [VOLT_W-1:0] mean_low_mv;
    logic [VOLT_W-1:0] mean_high_mv;
    logic [VOLT_W-1:0] min_mv;
    logic [VOLT_W-1:0] max_mv;
    logic [CNT_W-1:0]  ready_total;
    logic [CNT_W-1:0]  busy_total;
    logic [CNT_W-1:0]  error_total;
  } out_t;

  // Saturating increment of an event counter
  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
    sat_inc = (&c) ? c : c + CNT_W'(1);
  endfunction

endpackage

// ----- rtl/spm_div.sv -----
// Restoring serial divider, one quotient bit per cycle.
// Depends on spm_pkg for default widths.
module spm_div #(
  parameter int NUM_W = spm_pkg::SUM_W,
  parameter int DEN_W = spm_pkg::DIV_DEN_W
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] dividend,
  input  logic [DEN_W-1:0] divisor,
  output logic             done,
  output logic [NUM_W-1:0] quotient
);
  import spm_pkg::*;

  localparam int STEP_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0]  quo;
  logic [DEN_W-1:0]  rem;
  logic [DEN_W-1:0]  den;
  logic [STEP_W-1:0] steps;
  logic              busy;
  logic [DEN_W:0]    shifted;
  logic [DEN_W:0]    diff;
  logic              ge;
  logic [DEN_W-1:0]  rem_next;

  // One trial subtraction per cycle
  always_comb begin
    shifted  = {rem, quo[NUM_W-1]};
    ge       = shifted >= {1'b0, den};
    diff     = shifted - {1'b0, den};
    rem_next = ge ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        quo   <= dividend;
        rem   <= '0;
        den   <= divisor;
        steps <= STEP_W'(NUM_W);
        busy  <= 1'b1;
      end else if (busy) begin
        quo   <= {quo[NUM_W-2:0], ge};
        rem   <= rem_next;
        steps <= steps - STEP_W'(1);
        if (steps == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = quo;

endmodule

// ----- rtl/adc_square_wave_span_meter_core.sv -----
// Square-wave span meter core: one item at a time through a shared serial divider.
// A read runs one 40-step division, a window close runs two divisions, and an error or
// config mismatch skips the divider; opcode 3 is dropped with no result.
// The next item is taken the cycle after the result is registered, so a new item is
// accepted only once the last one is through and the output is not stalled.
// Reset (sync, active high): window cleared, min all ones, ratio 1/1, threshold all ones.
module adc_square_wave_span_meter_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          sample_valid,
  output logic                          sample_stall,
  input  spm_pkg::in_t                  sample,
  output logic                          result_valid,
  input  logic                          result_stall,
  output spm_pkg::out_t                 result,
  input  logic                          cfg_we,
  input  logic [spm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [spm_pkg::VOLT_W-1:0]    cfg_data
);
  import spm_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL,
    S_DIVSTART,
    S_SCALE,
    S_UPDATE,
    S_MEAN_LO,
    S_MEAN_HI,
    S_SUMMARY,
    S_DONE
  } state_t;

  state_t state;

  // Configuration
  logic [RATIO_W-1:0] num;
  logic [RATIO_W-1:0] den;
  logic [VOLT_W-1:0]  ovp;

  // Window statistics
  logic              level;
  logic [SUM_W-1:0]  sum_low;
  logic [SUM_W-1:0]  sum_high;
  logic [CNT_W-1:0]  count_low;
  logic [CNT_W-1:0]  count_high;
  logic [CNT_W-1:0]  ready_count;
  logic [CNT_W-1:0]  busy_count;
  logic [CNT_W-1:0]  error_count;
  logic [VOLT_W-1:0] min_seen;
  logic [VOLT_W-1:0] max_seen;

  // Working registers
  in_t               item;
  logic [PROD_W-1:0] prod;
  logic [VOLT_W-1:0] scaled;
  logic [VOLT_W-1:0] mean_low;
  out_t              res;

  // Divider interface
  logic                 div_start;
  logic [SUM_W-1:0]     div_num;
  logic [DIV_DEN_W-1:0] div_den;
  logic                 div_done;
  logic [SUM_W-1:0]     div_q;

  logic [RATIO_W-1:0] den_eff;
  logic [MV_W-1:0]    mv;
  logic [VOLT_W-1:0]  q_sat;
  logic [VOLT_W-1:0]  mean_high;

  // Result with only kind and level set, for items that skip the datapath
  function automatic out_t plain_result(input kind_t kind, input logic drv);
    out_t r;
    r             = '0;
    r.result_kind = kind;
    r.drive_level = drv;
    return r;
  endfunction

  spm_div #(
    .NUM_W (SUM_W),
    .DEN_W (DIV_DEN_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_num),
    .divisor  (div_den),
    .done     (div_done),
    .quotient (div_q)
  );

  assign sample_stall = (state != S_IDLE);

  // Operand selection for the shared divider
  always_comb begin
    den_eff   = (den == '0) ? RATIO_W'(1) : den;
    mv        = item.sample_word[15] ? '0 : item.sample_word[MV_W-1:0];
    q_sat     = (|div_q[SUM_W-1:VOLT_W]) ? '1 : div_q[VOLT_W-1:0];
    mean_high = (count_high == '0) ? '0 : div_q[VOLT_W-1:0];
    div_start = 1'b0;
    div_num   = SUM_W'(prod) + SUM_W'(den_eff >> 1);
    div_den   = DIV_DEN_W'(den_eff);
    unique case (state)
      S_IDLE: begin
        div_start = sample_valid && (sample.opcode == OP_CLOSE);
        div_num   = sum_low + SUM_W'(count_low >> 1);
        div_den   = DIV_DEN_W'(count_low);
      end
      S_DIVSTART: begin
        div_start = 1'b1;
      end
      S_MEAN_LO: begin
        div_start = div_done;
        div_num   = sum_high + SUM_W'(count_high >> 1);
        div_den   = DIV_DEN_W'(count_high);
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  // Sequencer, statistics and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
      num          <= RATIO_W'(1);
      den          <= RATIO_W'(1);
      ovp          <= '1;
      level        <= 1'b0;
      sum_low      <= '0;
      sum_high     <= '0;
      count_low    <= '0;
      count_high   <= '0;
      ready_count  <= '0;
      busy_count   <= '0;
      error_count  <= '0;
      min_seen     <= '1;
      max_seen     <= '0;
    end else begin
      // Take configuration writes
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_NUM: num <= cfg_data[RATIO_W-1:0];
          CFG_DEN: den <= cfg_data[RATIO_W-1:0];
          CFG_OVP: ovp <= cfg_data;
          default: ;
        endcase
      end

      // Drop a result once taken, unless a new one replaces it this cycle
      if (result_valid && !result_stall && (state != S_DONE)) begin
        result_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (sample_valid) begin
            item <= sample;
            unique case (opcode_t'(sample.opcode))
              OP_READ: begin
                if ((sample.status_byte & STATUS_CFG_MASK) != STATUS_CFG_EXPECT) begin
                  error_count <= sat_inc(error_count);
                  res         <= plain_result(KIND_MISMATCH, level);
                  state       <= S_DONE;
                end else begin
                  res   <= '0;
                  state <= S_MUL;
                end
              end
              OP_ERROR: begin
                error_count <= sat_inc(error_count);
                res         <= plain_result(KIND_ERROR, level);
                state       <= S_DONE;
              end
              OP_CLOSE: begin
                res   <= '0;
                state <= S_MEAN_LO;
              end
              OP_NONE: begin
                state <= S_IDLE;
              end
            endcase
          end
        end

        S_MUL: begin
          prod  <= PROD_W'(mv * num);
          state <= S_DIVSTART;
        end

        S_DIVSTART: begin
          state <= S_SCALE;
        end

        S_SCALE: begin
          if (div_done) begin
            scaled <= q_sat;
            state  <= S_UPDATE;
          end
        end

        S_UPDATE: begin
          // Fold a ready sample into the window; count a busy one
          if (!item.status_byte[STATUS_BUSY_BIT]) begin
            if (scaled < min_seen) min_seen <= scaled;
            if (scaled > max_seen) max_seen <= scaled;
            ready_count     <= sat_inc(ready_count);
            res.result_kind <= KIND_READY;
            if (level) begin
              if (!(&count_high)) begin
                sum_high   <= sum_high + SUM_W'(scaled);
                count_high <= count_high + CNT_W'(1);
              end
            end else begin
              if (!(&count_low)) begin
                sum_low   <= sum_low + SUM_W'(scaled);
                count_low <= count_low + CNT_W'(1);
              end
            end
          end else begin
            busy_count      <= sat_inc(busy_count);
            res.result_kind <= KIND_BUSY;
          end
          level            <= ~level;
          res.scaled_mv    <= scaled;
          res.over_voltage <= (scaled > ovp);
          res.drive_level  <= ~level;
          state            <= S_DONE;
        end

        S_MEAN_LO: begin
          if (div_done) begin
            mean_low <= (count_low == '0) ? '0 : div_q[VOLT_W-1:0];
            state    <= S_MEAN_HI;
          end
        end

        S_MEAN_HI: begin
          if (div_done) begin
            res.mean_high_mv <= mean_high;
            state            <= S_SUMMARY;
          end
        end

        S_SUMMARY: begin
          // Report the window, then clear it
          res.result_kind <= KIND_SUMMARY;
          res.drive_level <= level;
          res.mean_low_mv <= mean_low;
          res.span_mv     <= (res.mean_high_mv >= mean_low) ?
                             res.mean_high_mv - mean_low : mean_low - res.mean_high_mv;
          res.min_mv      <= (ready_count == '0) ? '0 : min_seen;
          res.max_mv      <= max_seen;
          res.ready_total <= ready_count;
          res.busy_total  <= busy_count;
          res.error_total <= error_count;
          sum_low         <= '0;
          sum_high        <= '0;
          count_low       <= '0;
          count_high      <= '0;
          ready_count     <= '0;
          busy_count      <= '0;
          error_count     <= '0;
          min_seen        <= '1;
          max_seen        <= '0;
          state           <= S_DONE;
        end

        S_DONE: begin
          // Hand the item to the output register once it is free
          if (!result_valid || !result_stall) begin
            result       <= res;
            result_valid <= 1'b1;
            state        <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
